>>> hdl/i2c_srb_pkg.sv
// Shared types and codes for the two-wire slave register bank.
package i2c_srb_pkg;

    localparam logic [2:0] OP_BUS_WR  = 3'd0;
    localparam logic [2:0] OP_BUS_RD  = 3'd1;
    localparam logic [2:0] OP_HOST_WR = 3'd2;
    localparam logic [2:0] OP_HOST_RD = 3'd3;
    localparam logic [2:0] OP_TICK    = 3'd4;

    localparam logic [1:0] CFG_REGS_IN_USE  = 2'd0;
    localparam logic [1:0] CFG_HEADER_COUNT = 2'd1;
    localparam logic [1:0] CFG_HEADER_WORD  = 2'd2;
    localparam logic [1:0] CFG_TIMEOUT      = 2'd3;

    localparam int IN_DATA_W  = 24;
    localparam int OUT_DATA_W = 16;

    typedef enum logic {
        S_IDLE,
        S_BUSY
    } t_state;

    typedef enum logic [1:0] {
        RD_ZERO,
        RD_HDR,
        RD_MEM
    } t_rd_src;

    typedef struct packed {
        logic exec;
        logic emit;
    } t_ctl_cmd;

endpackage

>>> hdl/i2c_srb_ctrl.sv
// Sequencer: accepts one item, then loads the output register when it is free.
module i2c_srb_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output i2c_srb_pkg::t_ctl_cmd o_cmd
);
    import i2c_srb_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        o_cmd       = '0;
        o_s_tready  = 1'b0;
        if (r_out_valid && i_m_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_BUSY;
                end
            end
            S_BUSY: begin
                if (!r_out_valid || i_m_tready) begin
                    o_cmd.emit  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;

endmodule

>>> hdl/i2c_srb_dp.sv
// Datapath: configuration, pointers, timeout, register store and result registers.
module i2c_srb_dp #(
    parameter int NUM_REGS   = 32,
    parameter int HEADER_MAX = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  i2c_srb_pkg::t_ctl_cmd               i_cmd,
    input  logic [i2c_srb_pkg::IN_DATA_W-1:0]   i_item,
    input  logic                                i_cfg_we,
    input  logic [1:0]                          i_cfg_index,
    input  logic [31:0]                         i_cfg_data,
    output logic [i2c_srb_pkg::OUT_DATA_W-1:0]  o_result
);
    import i2c_srb_pkg::*;

    localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int LEN_W = $clog2(NUM_REGS + 1);

    logic [2:0]  w_op;
    logic        w_first;
    logic [7:0]  w_data;
    logic [4:0]  w_hidx;

    logic [5:0]  r_regs;
    logic [2:0]  r_hcnt;
    logic [31:0] r_hword;
    logic [15:0] r_tticks;

    logic [IDX_W-1:0] r_ptr, n_ptr;
    logic [LEN_W-1:0] r_wpos, n_wpos;
    logic             r_wacc, n_wacc;
    logic [7:0]       r_rpos, n_rpos;
    logic [15:0]      r_tmo, n_tmo;

    logic [7:0]          mem [NUM_REGS];
    logic [NUM_REGS-1:0] r_vld;
    logic [7:0]          r_mem_q;
    logic                r_mem_ok;

    t_rd_src    r_sel, n_sel;
    logic [7:0] r_hbyte, n_hbyte;
    logic       r_conn, n_conn;
    logic       r_rej, n_rej;
    logic [7:0] r_ord;
    logic       r_oconn;
    logic       r_orej;

    logic [9:0]       w_alen;
    logic [3:0]       w_hc;
    logic [7:0]       w_pos;
    logic [9:0]       w_bidx;
    logic [9:0]       w_hidx10;
    logic [9:0]       w_wpos10;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    logic [IDX_W-1:0] w_raddr;

    assign w_op    = i_item[2:0];
    assign w_first = i_item[3];
    assign w_data  = i_item[11:4];
    assign w_hidx  = i_item[16:12];

    assign w_alen   = (10'(r_regs) < 10'(NUM_REGS)) ? 10'(r_regs) : 10'(NUM_REGS);
    assign w_hc     = (4'(r_hcnt) < 4'(HEADER_MAX)) ? 4'(r_hcnt) : 4'(HEADER_MAX);
    assign w_pos    = w_first ? 8'd0 : r_rpos;
    assign w_bidx   = 10'(r_ptr) + 10'(w_pos) - 10'(w_hc);
    assign w_hidx10 = 10'(w_hidx);
    assign w_wpos10 = 10'(r_wpos);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs   <= 6'd32;
            r_hcnt   <= 3'd0;
            r_hword  <= 32'd0;
            r_tticks <= 16'd1000;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_REGS_IN_USE:  r_regs   <= i_cfg_data[5:0];
                CFG_HEADER_COUNT: r_hcnt   <= i_cfg_data[2:0];
                CFG_HEADER_WORD:  r_hword  <= i_cfg_data;
                CFG_TIMEOUT:      r_tticks <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_ptr   = r_ptr;
        n_wpos  = r_wpos;
        n_wacc  = r_wacc;
        n_rpos  = r_rpos;
        n_tmo   = r_tmo;
        n_sel   = RD_ZERO;
        n_hbyte = 8'd0;
        n_rej   = 1'b0;
        w_we    = 1'b0;
        w_waddr = w_wpos10[IDX_W-1:0];
        w_raddr = w_hidx10[IDX_W-1:0];
        case (w_op)
            OP_BUS_WR: begin
                if (w_first) begin
                    if (10'(w_data) < w_alen) begin
                        n_ptr  = w_data[IDX_W-1:0];
                        n_wpos = w_data[LEN_W-1:0];
                        n_wacc = 1'b1;
                    end else begin
                        n_wacc = 1'b0;
                    end
                end else if (r_wacc && (w_wpos10 < w_alen)) begin
                    w_we   = 1'b1;
                    n_wpos = LEN_W'(w_wpos10 + 10'd1);
                end
                n_rej = !n_wacc;
                n_tmo = r_tticks;
            end
            OP_BUS_RD: begin
                if (4'(w_pos) < 4'(w_hc) && w_pos < 8'(w_hc)) begin
                    n_sel = RD_HDR;
                    if (w_pos < 8'd4) begin
                        n_hbyte = r_hword[8 * w_pos[1:0] +: 8];
                    end
                end else begin
                    w_raddr = w_bidx[IDX_W-1:0];
                    if (w_bidx < w_alen) begin
                        n_sel = RD_MEM;
                    end
                end
                n_rpos = (w_pos != 8'hFF) ? w_pos + 8'd1 : w_pos;
                n_tmo  = r_tticks;
            end
            OP_HOST_WR: begin
                w_waddr = w_hidx10[IDX_W-1:0];
                w_we    = (w_hidx10 < 10'(NUM_REGS));
            end
            OP_HOST_RD: begin
                if (w_hidx10 < 10'(NUM_REGS)) begin
                    n_sel = RD_MEM;
                end
            end
            OP_TICK: begin
                if (r_tmo != 16'd0) begin
                    n_tmo = r_tmo - 16'd1;
                end
            end
            default: ;
        endcase
        n_conn = (n_tmo != 16'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_wpos <= '0;
            r_wacc <= 1'b0;
            r_rpos <= 8'd0;
            r_tmo  <= 16'd0;
            r_vld  <= '0;
        end else if (i_cmd.exec) begin
            r_ptr  <= n_ptr;
            r_wpos <= n_wpos;
            r_wacc <= n_wacc;
            r_rpos <= n_rpos;
            r_tmo  <= n_tmo;
            if (w_we) begin
                r_vld[w_waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (w_we) begin
                mem[w_waddr] <= w_data;
            end
            r_mem_q  <= mem[w_raddr];
            r_mem_ok <= r_vld[w_raddr];
            r_sel    <= n_sel;
            r_hbyte  <= n_hbyte;
            r_conn   <= n_conn;
            r_rej    <= n_rej;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            case (r_sel)
                RD_HDR:  r_ord <= r_hbyte;
                RD_MEM:  r_ord <= r_mem_ok ? r_mem_q : 8'd0;
                default: r_ord <= 8'd0;
            endcase
            r_oconn <= r_conn;
            r_orej  <= r_rej;
        end
    end

    assign o_result = {6'd0, r_orej, r_oconn, r_ord};

endmodule

>>> hdl/i2c_slave_register_bank.sv
// Top level of the two-wire slave register bank.
// A transferred item's store read and header byte are registered first; the output register
// is then loaded from them once it is free. A new item is not accepted until the last one's
// result has been loaded into the output register.
// Reset (synchronous, active low): store reads as zero, pointers and timeout cleared,
// configuration back to 32 registers, no header, timeout of 1000 ticks.
module i2c_slave_register_bank #(
    parameter int NUM_REGS   = 32,
    parameter int HEADER_MAX = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // op[2:0], first_of_transfer[3], data_byte[11:4], host_index[16:12], zeros
    input  logic [23:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // read_data[7:0], connected[8], address_rejected[9], zeros
    output logic [15:0] o_m_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import i2c_srb_pkg::*;

    t_ctl_cmd w_cmd;

    assign o_cfg_ready = 1'b1;

    i2c_srb_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (w_cmd)
    );

    i2c_srb_dp #(
        .NUM_REGS   (NUM_REGS),
        .HEADER_MAX (HEADER_MAX)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_item      (i_s_tdata),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_result    (o_m_tdata)
    );

endmodule

>>> tb/i2c_slave_register_bank_tb.sv
// Self-checking bench for the two-wire slave register bank: stream stimulus, live prediction.
module i2c_slave_register_bank_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import i2c_srb_pkg::*;

    localparam int NUM_REGS   = 32;
    localparam int HEADER_MAX = 4;
    localparam int LIMIT      = 300000;

    typedef struct packed {
        logic [4:0] host_index;
        logic [7:0] data_byte;
        logic       first;
        logic [2:0] op;
    } t_bank_item;

    typedef struct packed {
        logic       address_rejected;
        logic       connected;
        logic [7:0] read_data;
    } t_bank_result;

    class bank_scoreboard;
        logic [5:0]   regs_in_use;
        logic [2:0]   header_count;
        logic [31:0]  header_word;
        logic [15:0]  timeout_ticks;
        logic [7:0]   store [NUM_REGS];
        int           pointer;
        int           wr_pos;
        bit           wr_ok;
        int           rd_pos;
        logic [15:0]  tmo;
        t_bank_result expected_q [$];
        int           errors;
        int           checked;

        function new();
            foreach (store[i]) store[i] = 8'h00;
            pointer       = 0;
            wr_pos        = 0;
            wr_ok         = 0;
            rd_pos        = 0;
            tmo           = 16'd0;
            regs_in_use   = 6'd32;
            header_count  = 3'd0;
            header_word   = 32'd0;
            timeout_ticks = 16'd1000;
            errors        = 0;
            checked       = 0;
        endfunction

        function int bus_len();
            return (regs_in_use < NUM_REGS) ? int'(regs_in_use) : NUM_REGS;
        endfunction

        function int hdr_len();
            return (header_count < HEADER_MAX) ? int'(header_count) : HEADER_MAX;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_cfg(logic [1:0] idx, logic [31:0] data);
            case (idx)
                CFG_REGS_IN_USE:  regs_in_use   = data[5:0];
                CFG_HEADER_COUNT: header_count  = data[2:0];
                CFG_HEADER_WORD:  header_word   = data;
                CFG_TIMEOUT:      timeout_ticks = data[15:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] bus_byte(int pos);
            int hc;
            int idx;
            hc = hdr_len();
            if (pos < hc) begin
                if (pos < 4) return 8'((header_word >> (pos * 8)) & 32'hFF);
                return 8'h00;
            end
            idx = pointer + (pos - hc);
            if (idx < bus_len() && idx < NUM_REGS) return store[idx];
            return 8'h00;
        endfunction

        function void note_item(t_bank_item it);
            t_bank_result r;
            r = '0;
            case (it.op)
                OP_BUS_WR: begin
                    if (it.first) begin
                        if (int'(it.data_byte) < bus_len()) begin
                            pointer = int'(it.data_byte);
                            wr_pos  = int'(it.data_byte);
                            wr_ok   = 1;
                        end else begin
                            wr_ok = 0;
                        end
                    end else if (wr_ok && wr_pos < bus_len() && wr_pos < NUM_REGS) begin
                        store[wr_pos] = it.data_byte;
                        wr_pos++;
                    end
                    r.address_rejected = !wr_ok;
                    tmo = timeout_ticks;
                end
                OP_BUS_RD: begin
                    if (it.first) rd_pos = 0;
                    r.read_data = bus_byte(rd_pos);
                    if (rd_pos < 255) rd_pos++;
                    tmo = timeout_ticks;
                end
                OP_HOST_WR: begin
                    if (it.host_index < NUM_REGS) store[it.host_index] = it.data_byte;
                end
                OP_HOST_RD: begin
                    if (it.host_index < NUM_REGS) r.read_data = store[it.host_index];
                end
                OP_TICK: begin
                    if (tmo != 16'd0) tmo--;
                end
                default: ;
            endcase
            r.connected = (tmo != 16'd0);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [15:0] tdata);
            t_bank_result exp;
            t_bank_result got;
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer: tdata %h", tdata);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            got = tdata[9:0];
            checked++;
            if (got.read_data !== exp.read_data) begin
                $error("read_data: expected %h, got %h", exp.read_data, got.read_data);
                errors++;
            end
            if (got.connected !== exp.connected) begin
                $error("connected: expected %b, got %b", exp.connected, got.connected);
                errors++;
            end
            if (got.address_rejected !== exp.address_rejected) begin
                $error("address_rejected: expected %b, got %b",
                       exp.address_rejected, got.address_rejected);
                errors++;
            end
            if (tdata[15:10] !== 6'd0) begin
                $error("padding: expected %h, got %h", 6'd0, tdata[15:10]);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    bank_scoreboard sb = new();
    int  cycle_count = 0;
    int  items_sent = 0;
    int  settings_used = 0;
    bit  steady = 1'b0;

    i2c_slave_register_bank #(
        .NUM_REGS   (NUM_REGS),
        .HEADER_MAX (HEADER_MAX)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        .o_m_tdata   (m_tdata),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin
        wait (cycle_count >= LIMIT);
        $display("Timed out after %0d cycles with %0d results outstanding",
                 cycle_count, sb.pending());
        $display("FAIL");
        $finish;
    end

    initial begin
        int stall;
        @(posedge i_clk);
        wait (rst_n);
        forever begin
            stall = steady ? 0 : $urandom_range(0, 5);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            do @(posedge i_clk); while (!m_tvalid);
            sb.check_result(m_tdata);
        end
    end

    task automatic send(input logic [2:0] op, input logic first,
                        input logic [7:0] data, input logic [4:0] idx);
        t_bank_item it;
        int gap;
        it  = '{host_index: idx, data_byte: data, first: first, op: op};
        gap = steady ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'd0, it};
        do @(posedge i_clk); while (!s_tready);
        sb.note_item(it);
        items_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_put(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge i_clk); while (!cfg_ready);
        sb.write_cfg(idx, data);
    endtask

    // upper bits beyond each register's width carry noise
    task automatic set_config(input logic [5:0] regs, input logic [2:0] hc,
                              input logic [31:0] hw, input logic [15:0] tmo);
        cfg_put(CFG_REGS_IN_USE, ($urandom() & 32'hFFFF_FFC0) | 32'(regs));
        cfg_put(CFG_HEADER_COUNT, ($urandom() & 32'hFFFF_FFF8) | 32'(hc));
        cfg_put(CFG_HEADER_WORD, hw);
        cfg_put(CFG_TIMEOUT, ($urandom() & 32'hFFFF_0000) | 32'(tmo));
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic bus_write_run();
        int len;
        int n;
        logic [7:0] addr;
        len = sb.bus_len();
        if (len > 0 && $urandom_range(0, 3) != 0) addr = 8'($urandom_range(0, len - 1));
        else addr = 8'($urandom_range(0, 255));
        send(OP_BUS_WR, 1'b1, addr, 5'($urandom_range(0, 31)));
        n = $urandom_range(0, 10);
        repeat (n) send(OP_BUS_WR, 1'b0, 8'($urandom_range(0, 255)),
                        5'($urandom_range(0, 31)));
    endtask

    task automatic bus_read_run(input int n);
        send(OP_BUS_RD, 1'b1, 8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
        repeat (n - 1) send(OP_BUS_RD, 1'b0, 8'($urandom_range(0, 255)),
                            5'($urandom_range(0, 31)));
    endtask

    task automatic run_phase(input int n_items);
        int start;
        int pick;
        start = items_sent;
        while (items_sent - start < n_items) begin
            steady = ($urandom_range(0, 3) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 30) begin
                bus_write_run();
            end else if (pick < 55) begin
                bus_read_run($urandom_range(1, 9));
            end else if (pick < 70) begin
                send($urandom_range(0, 1) ? OP_HOST_WR : OP_HOST_RD,
                     1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     5'($urandom_range(0, 31)));
            end else if (pick < 85) begin
                repeat ($urandom_range(1, 8))
                    send(OP_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         5'($urandom_range(0, 31)));
            end else begin
                repeat ($urandom_range(1, 3))
                    send(3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)),
                         8'($urandom_range(0, 255)), 5'($urandom_range(0, 31)));
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);

        // default settings: continuation before any address, range edges, host access, a tick, unused op codes
        send(OP_BUS_WR, 1'b0, 8'h5A, 5'd0);
        send(OP_BUS_RD, 1'b0, 8'h00, 5'd0);
        send(OP_BUS_WR, 1'b1, 8'h00, 5'd0);
        send(OP_BUS_WR, 1'b0, 8'hFF, 5'd0);
        send(OP_BUS_WR, 1'b0, 8'h00, 5'd0);
        send(OP_BUS_WR, 1'b1, 8'd31, 5'd31);
        send(OP_BUS_WR, 1'b0, 8'h81, 5'd0);
        send(OP_BUS_WR, 1'b0, 8'h7E, 5'd0);
        send(OP_BUS_WR, 1'b1, 8'd32, 5'd0);
        send(OP_BUS_WR, 1'b0, 8'h33, 5'd0);
        send(OP_BUS_WR, 1'b1, 8'hFF, 5'd0);
        send(OP_BUS_RD, 1'b1, 8'h00, 5'd0);
        send(OP_BUS_RD, 1'b0, 8'h00, 5'd0);
        send(OP_HOST_WR, 1'b0, 8'hA5, 5'd31);
        send(OP_HOST_WR, 1'b1, 8'h00, 5'd0);
        send(OP_HOST_RD, 1'b0, 8'h00, 5'd31);
        send(OP_HOST_RD, 1'b0, 8'h00, 5'd0);
        send(OP_HOST_RD, 1'b1, 8'hFF, 5'd1);
        send(OP_TICK, 1'b0, 8'h00, 5'd0);
        send(3'd5, 1'b1, 8'hFF, 5'd31);
        send(3'd6, 1'b1, 8'hFF, 5'd31);
        send(3'd7, 1'b1, 8'hFF, 5'd31);
        drain();

        set_config(6'd32, 3'd4, 32'hA5C3_0F1E, 16'd5);
        run_phase(60);
        // long read to saturate the read position
        steady = 1'b1;
        bus_read_run(262);
        drain();

        set_config(6'd1, 3'd0, 32'd0, 16'd0);
        run_phase(50);
        drain();

        set_config(6'd0, 3'd7, 32'hFFFF_FFFF, 16'd1);
        run_phase(50);
        drain();

        set_config(6'd63, 3'd2, $urandom(), 16'hFFFF);
        run_phase(50);
        drain();

        repeat (3) begin
            set_config(6'($urandom_range(0, 63)), 3'($urandom_range(0, 7)), $urandom(),
                       16'($urandom_range(0, 12)));
            run_phase(35);
            drain();
        end

        $display("Sent %0d items and checked %0d results across %0d register settings",
                 items_sent, sb.checked, settings_used);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
